>>> rtl/mfrd_pkg.sv
// Shared types and constants for the meter frame ratio decoder.
// No dependencies; imported by mfrd_ctrl, mfrd_datapath and the top unit.
package mfrd_pkg;

    localparam int WORD_BITS   = 24;
    localparam int RATIO_BITS  = 40;
    localparam int STORE_DEPTH = 18;
    localparam int POS_BITS    = 5;
    localparam int RATIO_COUNT = 3;

    localparam logic [7:0] SYNC_FIRST  = 8'h55;
    localparam logic [7:0] SYNC_SECOND = 8'h5A;

    typedef enum logic [2:0] {
        ST_HUNT,
        ST_SYNC1,
        ST_BODY,
        ST_DLOAD,
        ST_DSTEP,
        ST_DNEXT,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        SEL_VOLTAGE,
        SEL_CURRENT,
        SEL_POWER
    } ratio_sel_t;

    typedef struct packed {
        logic                store_en;
        logic [POS_BITS-1:0] store_pos;
        ratio_sel_t          sel;
        logic                div_load;
        logic                div_step;
        logic                div_commit;
        logic                out_load;
    } cmd_t;

    typedef struct packed {
        logic [7:0] rx_byte;
    } in_word_t;

    typedef struct packed {
        logic [RATIO_BITS-1:0] voltage_ratio;
        logic [RATIO_BITS-1:0] current_ratio;
        logic [RATIO_BITS-1:0] power_ratio;
        logic                  voltage_div_zero;
        logic                  current_div_zero;
        logic                  power_div_zero;
    } out_word_t;

endpackage

>>> rtl/mfrd_stream_if.sv
// Valid/ready channel carrying one word of a given payload type.
// No dependencies.
interface mfrd_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/mfrd_ctrl.sv
// Controller: sync hunt, body byte count, divider sequencing, output valid.
// Depends on mfrd_pkg.
module mfrd_ctrl import mfrd_pkg::*; #(
    parameter int FRAME_BYTES = 24,
    parameter int QUOT_BITS   = 40
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       rx_valid,
    input  logic [7:0] rx_byte,
    output logic       rx_ready,
    output logic       result_valid,
    input  logic       result_ready,
    output cmd_t       cmd
);
    localparam int CNT_BITS = $clog2(QUOT_BITS);
    localparam logic [POS_BITS:0] LAST_SUM = (POS_BITS + 1)'(FRAME_BYTES);

    state_t              state_reg, state_next;
    logic [POS_BITS-1:0] pos_reg, pos_next;
    ratio_sel_t          sel_reg, sel_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_HUNT;
            pos_reg       <= '0;
            sel_reg       <= SEL_VOLTAGE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            sel_reg       <= sel_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        sel_next   = sel_reg;
        cnt_next   = cnt_reg;
        rx_ready   = 1'b0;
        cmd        = '0;
        cmd.store_pos = pos_reg;
        cmd.sel       = sel_reg;
        unique case (state_reg)
            ST_HUNT:
            begin
                rx_ready = 1'b1;
                if (rx_valid)
                    state_next = (rx_byte == SYNC_FIRST) ? ST_SYNC1 : ST_HUNT;
            end
            ST_SYNC1:
            begin
                rx_ready = 1'b1;
                if (rx_valid)
                begin
                    if (rx_byte == SYNC_SECOND)
                    begin
                        state_next = ST_BODY;
                        pos_next   = '0;
                    end
                    else
                        state_next = ST_HUNT;
                end
            end
            ST_BODY:
            begin
                rx_ready = 1'b1;
                if (rx_valid)
                begin
                    cmd.store_en = (pos_reg < POS_BITS'(STORE_DEPTH));
                    pos_next     = pos_reg + 1'b1;
                    if ({1'b0, pos_reg} + (POS_BITS + 1)'(3) >= LAST_SUM)
                    begin
                        state_next = ST_DLOAD;
                        pos_next   = '0;
                        sel_next   = SEL_VOLTAGE;
                    end
                end
            end
            ST_DLOAD:
            begin
                cmd.div_load = 1'b1;
                cnt_next     = CNT_BITS'(QUOT_BITS - 1);
                state_next   = ST_DSTEP;
            end
            ST_DSTEP:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = ST_DNEXT;
            end
            ST_DNEXT:
            begin
                cmd.div_commit = 1'b1;
                if (sel_reg == SEL_POWER)
                    state_next = ST_OUT;
                else
                begin
                    sel_next   = (sel_reg == SEL_VOLTAGE) ? SEL_CURRENT : SEL_POWER;
                    state_next = ST_DLOAD;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_HUNT;
                end
            end
            default:
                state_next = ST_HUNT;
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_valid_reg && result_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign result_valid = out_valid_reg;

endmodule

>>> rtl/mfrd_datapath.sv
// Datapath: frame byte store, bit-serial restoring divider, result staging.
// Depends on mfrd_pkg.
module mfrd_datapath import mfrd_pkg::*; #(
    parameter int FRACTION_BITS = 16
) (
    input  logic       clk,
    input  logic [7:0] rx_byte,
    input  cmd_t       cmd,
    output out_word_t  result
);
    localparam int QUOT_BITS = WORD_BITS + FRACTION_BITS;

    logic [7:0]            byte_reg [STORE_DEPTH];
    logic [WORD_BITS-1:0]  den_reg;
    logic [WORD_BITS-1:0]  rem_reg, rem_next;
    logic [QUOT_BITS-1:0]  dvd_reg, dvd_next;
    logic [RATIO_BITS-1:0] ratio_reg [RATIO_COUNT];
    logic                  zero_reg  [RATIO_COUNT];
    out_word_t             out_reg;

    logic [WORD_BITS-1:0]  num_sel, den_sel;
    logic [WORD_BITS:0]    shifted, diff;
    logic                  ge;
    logic [63:0]           quot_ext;
    logic                  den_zero, quot_sat;
    logic [RATIO_BITS-1:0] ratio_val;

    function automatic logic [WORD_BITS-1:0] word_at(input int k,
                                                     input logic [7:0] b [STORE_DEPTH]);
        word_at = {b[3*k], b[3*k+1], b[3*k+2]};
    endfunction

    always_comb
    begin
        unique case (cmd.sel)
            SEL_VOLTAGE:
            begin
                num_sel = word_at(0, byte_reg);
                den_sel = word_at(1, byte_reg);
            end
            SEL_CURRENT:
            begin
                num_sel = word_at(2, byte_reg);
                den_sel = word_at(3, byte_reg);
            end
            SEL_POWER:
            begin
                num_sel = word_at(4, byte_reg);
                den_sel = word_at(5, byte_reg);
            end
            default:
            begin
                num_sel = '0;
                den_sel = '0;
            end
        endcase
    end

    // one quotient bit per step
    assign shifted  = {rem_reg, dvd_reg[QUOT_BITS-1]};
    assign ge       = (shifted >= {1'b0, den_reg});
    assign diff     = shifted - {1'b0, den_reg};
    assign rem_next = ge ? diff[WORD_BITS-1:0] : shifted[WORD_BITS-1:0];
    assign dvd_next = {dvd_reg[QUOT_BITS-2:0], ge};

    assign quot_ext  = 64'(dvd_reg);
    assign den_zero  = (den_reg == '0);
    assign quot_sat  = |quot_ext[63:RATIO_BITS];
    assign ratio_val = den_zero ? '0 : (quot_sat ? '1 : quot_ext[RATIO_BITS-1:0]);

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < STORE_DEPTH; i++)
        begin
            if (cmd.store_en && cmd.store_pos == POS_BITS'(i))
                byte_reg[i] <= rx_byte;
        end
        if (cmd.div_load)
        begin
            den_reg <= den_sel;
            rem_reg <= '0;
            dvd_reg <= QUOT_BITS'(num_sel) << FRACTION_BITS;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            dvd_reg <= dvd_next;
        end
        if (cmd.div_commit)
        begin
            ratio_reg[cmd.sel] <= ratio_val;
            zero_reg[cmd.sel]  <= den_zero;
        end
        if (cmd.out_load)
        begin
            out_reg.voltage_ratio    <= ratio_reg[SEL_VOLTAGE];
            out_reg.current_ratio    <= ratio_reg[SEL_CURRENT];
            out_reg.power_ratio      <= ratio_reg[SEL_POWER];
            out_reg.voltage_div_zero <= zero_reg[SEL_VOLTAGE];
            out_reg.current_div_zero <= zero_reg[SEL_CURRENT];
            out_reg.power_div_zero   <= zero_reg[SEL_POWER];
        end
    end

    assign result = out_reg;

endmodule

>>> rtl/meter_frame_ratio_decoder_unit.sv
// Meter frame decoder: sync hunt, frame collection, three Q fixed-point ratios.
// Takes one byte per cycle while rx.ready is high; after the last frame byte the
// shared bit-serial divider computes the three ratios in turn, then the result
// word is registered once the output is free. rx.ready is low meanwhile.
// Reset (async, active low) returns to sync hunt and clears the output valid.
// Depends on mfrd_pkg, mfrd_stream_if, mfrd_ctrl and mfrd_datapath.
module meter_frame_ratio_decoder_unit import mfrd_pkg::*; #(
    parameter int FRAME_BYTES   = 24,
    parameter int FRACTION_BITS = 16
) (
    input logic            clk,
    input logic            rst_n,
    mfrd_stream_if.sink    rx,
    mfrd_stream_if.source  result
);
    cmd_t      cmd;
    in_word_t  rx_word;
    out_word_t res_word;

    assign rx_word = rx.data;

    mfrd_ctrl #(
        .FRAME_BYTES (FRAME_BYTES),
        .QUOT_BITS   (WORD_BITS + FRACTION_BITS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .rx_valid     (rx.valid),
        .rx_byte      (rx_word.rx_byte),
        .rx_ready     (rx.ready),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .cmd          (cmd)
    );

    mfrd_datapath #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .clk     (clk),
        .rx_byte (rx_word.rx_byte),
        .cmd     (cmd),
        .result  (res_word)
    );

    assign result.data = res_word;

endmodule
